// ----- design/plane_intersection_direction_core_defines.svh -----
// Shared assertion macros for the plane intersection core.
`ifndef PLANE_INTERSECTION_DIRECTION_CORE_DEFINES_SVH
`define PLANE_INTERSECTION_DIRECTION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PID_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pid_pkg.sv -----
package pid_pkg;

   // Default fraction width and queue depth.
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Width of the exact elimination results a and b.
   localparam int WIDE_W = 128;

   // Number of registered stages in the elimination front end.
   localparam int FRONT_STAGES = 7;

   // Quotient limits: sticky overflow mark and saturation bounds.
   localparam logic [31:0] QUO_CAP     = 32'h8000_0001;
   localparam logic [31:0] QUO_MAX_NEG = 32'h8000_0000;
   localparam logic [31:0] QUO_MAX_POS = 32'h7fff_ffff;

   // Output saturation bounds.
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] first_u_x;
      logic signed [31:0] first_u_y;
      logic signed [31:0] first_u_z;
      logic signed [31:0] first_v_x;
      logic signed [31:0] first_v_y;
      logic signed [31:0] first_v_z;
      logic signed [31:0] second_u_x;
      logic signed [31:0] second_u_y;
      logic signed [31:0] second_u_z;
      logic signed [31:0] second_v_x;
      logic signed [31:0] second_v_y;
      logic signed [31:0] second_v_z;
   } pid_req_type;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic               parallel_flag;
   } pid_rsp_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      logic [WIDE_W-1:0] a_mag;
      logic [WIDE_W-1:0] b_mag;
      logic              quo_neg;
      logic              par;
      logic [2:0][31:0]  u2;
      logic [2:0][31:0]  v2;
   } pid_cls_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pid_queue_status_type;

endpackage

// ----- design/pid_front.sv -----
`include "plane_intersection_direction_core_defines.svh"

module pid_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pid_pkg::pid_req_type           req_data,
   output logic                           push,
   output pid_pkg::pid_cls_type           push_data,
   input  pid_pkg::pid_queue_status_type  queue_status
);
   import pid_pkg::*;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic                    front_en;

   logic signed [31:0] u1 [3];
   logic signed [31:0] v1 [3];
   logic signed [31:0] u2 [3];
   logic signed [31:0] v2 [3];
   logic signed [32:0] m [3][4];
   logic [2:0][31:0]   u2_pk, v2_pk;

   // Stage 1: first-stage cross products.
   logic signed [65:0] cp_ff [2][3][2];
   logic signed [65:0] cp_in [2][3][2];
   // Stage 2: rows after the first elimination.
   logic signed [65:0] rd [2][3];
   logic [63:0]        r_ff [2][3];
   logic [63:0]        r_in [2][3];
   // Stage 3: partial products of the 32-bit halves of the four wide products.
   logic [63:0]        xs [4];
   logic [63:0]        ys [4];
   logic signed [31:0] xh [4];
   logic signed [31:0] yh [4];
   logic signed [32:0] xl [4];
   logic signed [32:0] yl [4];
   logic signed [63:0] hh_ff [4], hh_in [4];
   logic signed [64:0] hl_ff [4], hl_in [4];
   logic signed [64:0] lh_ff [4], lh_in [4];
   logic [63:0]        ll_ff [4], ll_in [4];
   // Stage 4: middle sums and outer concatenation.
   logic [65:0]        mid_ff [4], mid_in [4];
   logic [WIDE_W-1:0]  cat_ff [4], cat_in [4];
   // Stage 5: full products.
   logic [WIDE_W-1:0]  prod_ff [4], prod_in [4];
   // Stage 6: coefficients a and b.
   logic [WIDE_W-1:0]  a_ff, a_in, b_ff, b_in;
   // Stage 7: classified item.
   pid_cls_type        cls_ff, cls_in;

   // Second plane vectors travel alongside the arithmetic.
   logic [2:0][31:0]   u2_ff [FRONT_STAGES-1];
   logic [2:0][31:0]   v2_ff [FRONT_STAGES-1];

   // The pipeline moves unless a finished item cannot enter the queue.
   assign front_en  = !valid_ff[FRONT_STAGES-1] || !queue_status.full;
   assign req_stall = !front_en;
   assign push      = valid_ff[FRONT_STAGES-1] && !queue_status.full;
   assign push_data = cls_ff;
   assign valid_in  = {valid_ff[FRONT_STAGES-2:0], req_valid};

   // Unpack the request into the elimination columns.
   always_comb begin
      u1[0] = req_data.first_u_x;  u1[1] = req_data.first_u_y;  u1[2] = req_data.first_u_z;
      v1[0] = req_data.first_v_x;  v1[1] = req_data.first_v_y;  v1[2] = req_data.first_v_z;
      u2[0] = req_data.second_u_x; u2[1] = req_data.second_u_y; u2[2] = req_data.second_u_z;
      v2[0] = req_data.second_v_x; v2[1] = req_data.second_v_y; v2[2] = req_data.second_v_z;
      for (int k = 0; k < 3; k++) begin
         m[k][0]  = {u1[k][31], u1[k]};
         m[k][1]  = {v1[k][31], v1[k]};
         m[k][2]  = -{u2[k][31], u2[k]};
         m[k][3]  = -{v2[k][31], v2[k]};
         u2_pk[k] = u2[k];
         v2_pk[k] = v2[k];
      end
      for (int j = 0; j < 3; j++) begin
         cp_in[0][j][0] = m[0][0] * m[1][j+1];
         cp_in[0][j][1] = m[1][0] * m[0][j+1];
         cp_in[1][j][0] = m[0][0] * m[2][j+1];
         cp_in[1][j][1] = m[2][0] * m[0][j+1];
      end
   end

   // Row differences, kept to 64 bits where the true value fits.
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         for (int j = 0; j < 3; j++) begin
            rd[r][j]   = cp_ff[r][j][0] - cp_ff[r][j][1];
            r_in[r][j] = rd[r][j][63:0];
         end
      end
   end

   // Split each 64 by 64 product into four partial products of its 32-bit halves.
   always_comb begin
      xs[0] = r_ff[0][0]; ys[0] = r_ff[1][1];
      xs[1] = r_ff[1][0]; ys[1] = r_ff[0][1];
      xs[2] = r_ff[0][0]; ys[2] = r_ff[1][2];
      xs[3] = r_ff[1][0]; ys[3] = r_ff[0][2];
      for (int i = 0; i < 4; i++) begin
         xh[i]    = signed'(xs[i][63:32]);
         yh[i]    = signed'(ys[i][63:32]);
         xl[i]    = signed'({1'b0, xs[i][31:0]});
         yl[i]    = signed'({1'b0, ys[i][31:0]});
         hh_in[i] = xh[i] * yh[i];
         hl_in[i] = xh[i] * yl[i];
         lh_in[i] = xl[i] * yh[i];
         ll_in[i] = xs[i][31:0] * ys[i][31:0];
      end
   end

   // Combine partials into the four wide products, then form a and b from their differences.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mid_in[i]  = {hl_ff[i][64], hl_ff[i]} + {lh_ff[i][64], lh_ff[i]};
         cat_in[i]  = {hh_ff[i], ll_ff[i]};
         prod_in[i] = cat_ff[i] + ({{(WIDE_W-66){mid_ff[i][65]}}, mid_ff[i]} << 32);
      end
      a_in = prod_ff[0] - prod_ff[1];
      b_in = prod_ff[2] - prod_ff[3];
   end

   // Classify: parallel planes, quotient sign and magnitudes.
   always_comb begin
      cls_in.par     = (a_ff == '0);
      cls_in.quo_neg = (b_ff != '0) && (a_ff[WIDE_W-1] == b_ff[WIDE_W-1]);
      cls_in.a_mag   = a_ff[WIDE_W-1] ? -a_ff : a_ff;
      cls_in.b_mag   = b_ff[WIDE_W-1] ? -b_ff : b_ff;
      cls_in.u2      = u2_ff[FRONT_STAGES-2];
      cls_in.v2      = v2_ff[FRONT_STAGES-2];
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (front_en) begin
         valid_ff <= valid_in;
      end
   end

   // Datapath registers advance together.
   always_ff @(posedge clock) begin
      if (front_en) begin
         cp_ff    <= cp_in;
         r_ff     <= r_in;
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         lh_ff    <= lh_in;
         ll_ff    <= ll_in;
         mid_ff   <= mid_in;
         cat_ff   <= cat_in;
         prod_ff  <= prod_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         cls_ff   <= cls_in;
         u2_ff[0] <= u2_pk;
         v2_ff[0] <= v2_pk;
         for (int s = 1; s < FRONT_STAGES - 1; s++) begin
            u2_ff[s] <= u2_ff[s-1];
            v2_ff[s] <= v2_ff[s-1];
         end
      end
   end

   // A finished item blocked by a full queue must stay put.
   `PID_ASSERT_NEXT(a_front_hold, clock, reset, valid_ff[FRONT_STAGES-1] && queue_status.full, valid_ff[FRONT_STAGES-1] && $stable(cls_ff), "front item lost while queue full")

endmodule

// ----- design/pid_queue.sv -----
`include "plane_intersection_direction_core_defines.svh"

module pid_queue #(
   parameter int DEPTH = pid_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  pid_pkg::pid_cls_type          push_data,
   input  logic                          pop,
   output pid_pkg::pid_cls_type          pop_data,
   output pid_pkg::pid_queue_status_type status
);
   import pid_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pid_cls_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PID_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `PID_ASSERT_NEXT(a_queue_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue push not counted")

endmodule

// ----- design/pid_back.sv -----
`include "plane_intersection_direction_core_defines.svh"

module pid_back #(
   parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          pop,
   input  pid_pkg::pid_cls_type          pop_data,
   input  pid_pkg::pid_queue_status_type queue_status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pid_pkg::pid_rsp_type          rsp_data
);
   import pid_pkg::*;

   // One quotient bit per stage: all numerator bits, then the fraction bits.
   localparam int DIV_STAGES = WIDE_W + FRAC_BITS;
   localparam int OUT_IDX    = DIV_STAGES + 3;

   typedef struct packed {
      logic [WIDE_W-1:0] rem;
      logic [WIDE_W-1:0] num;
      logic [WIDE_W-1:0] den;
      logic [31:0]       quo;
      logic              neg;
      logic              par;
      logic [2:0][31:0]  u2;
      logic [2:0][31:0]  v2;
   } div_stage_type;

   // One restoring division step with sticky overflow on the quotient.
   function automatic div_stage_type div_step(div_stage_type s);
      logic [WIDE_W-1:0] sh;
      logic [32:0]       qt;
      div_stage_type     r;
      r     = s;
      sh    = {s.rem[WIDE_W-2:0], s.num[WIDE_W-1]};
      r.num = {s.num[WIDE_W-2:0], 1'b0};
      if (sh >= s.den) begin
         r.rem = sh - s.den;
         qt    = {s.quo, 1'b1};
      end else begin
         r.rem = sh;
         qt    = {s.quo, 1'b0};
      end
      r.quo = (qt > {1'b0, QUO_CAP}) ? QUO_CAP : qt[31:0];
      return r;
   endfunction

   logic [OUT_IDX:0]   valid_ff, valid_in;
   logic               back_en;

   div_stage_type      div_ff [DIV_STAGES+1];
   div_stage_type      div_in [DIV_STAGES+1];

   logic signed [31:0] qv_ff, qv_in;
   logic               q_par_ff;
   logic [2:0][31:0]   q_u2_ff, q_v2_ff;

   logic signed [63:0] prod_ff [3], prod_in [3];
   logic               m_par_ff;
   logic [2:0][31:0]   m_u2_ff, m_v2_ff;

   logic signed [63:0] shv [3];
   logic [64:0]        sum [3];
   logic [31:0]        dir [3];
   pid_rsp_type        rsp_ff, rsp_in;

   // The whole back end advances unless a result waits on a stall.
   assign back_en   = !valid_ff[OUT_IDX] || !rsp_stall;
   assign pop       = back_en && !queue_status.empty;
   assign valid_in  = {valid_ff[OUT_IDX-1:0], !queue_status.empty};
   assign rsp_valid = valid_ff[OUT_IDX];
   assign rsp_data  = rsp_ff;

   // Load a queue entry as the first division stage.
   always_comb begin
      div_in[0].rem = '0;
      div_in[0].num = pop_data.b_mag;
      div_in[0].den = pop_data.a_mag;
      div_in[0].quo = '0;
      div_in[0].neg = pop_data.quo_neg;
      div_in[0].par = pop_data.par;
      div_in[0].u2  = pop_data.u2;
      div_in[0].v2  = pop_data.v2;
   end

   // Division stages.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      assign div_in[k+1] = div_step(div_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         div_ff <= div_in;
      end
   end

   // Saturate the quotient magnitude and apply its sign.
   always_comb begin
      if (div_ff[DIV_STAGES].neg) begin
         qv_in = (div_ff[DIV_STAGES].quo > QUO_MAX_NEG) ? signed'(QUO_MAX_NEG)
               : -signed'(div_ff[DIV_STAGES].quo);
      end else begin
         qv_in = (div_ff[DIV_STAGES].quo > QUO_MAX_POS) ? signed'(QUO_MAX_POS)
               : signed'(div_ff[DIV_STAGES].quo);
      end
   end

   // Scale u2 by the quotient, add v2, saturate; parallel planes pass u2.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = qv_ff * signed'(q_u2_ff[k]);
         shv[k]     = prod_ff[k] >>> FRAC_BITS;
         sum[k]     = {shv[k][63], shv[k]} + {{33{m_v2_ff[k][31]}}, m_v2_ff[k]};
         if (sum[k][64:31] != {34{sum[k][64]}}) begin
            dir[k] = sum[k][64] ? SAT_MIN : SAT_MAX;
         end else begin
            dir[k] = sum[k][31:0];
         end
         if (m_par_ff) begin
            dir[k] = m_u2_ff[k];
         end
      end
      rsp_in.dir_x         = dir[0];
      rsp_in.dir_y         = dir[1];
      rsp_in.dir_z         = dir[2];
      rsp_in.parallel_flag = m_par_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (back_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         qv_ff    <= qv_in;
         q_par_ff <= div_ff[DIV_STAGES].par;
         q_u2_ff  <= div_ff[DIV_STAGES].u2;
         q_v2_ff  <= div_ff[DIV_STAGES].v2;
         prod_ff  <= prod_in;
         m_par_ff <= q_par_ff;
         m_u2_ff  <= q_u2_ff;
         m_v2_ff  <= q_v2_ff;
         rsp_ff   <= rsp_in;
      end
   end

   `PID_ASSERT_IMPL(a_quo_cap, clock, reset, valid_ff[DIV_STAGES], div_ff[DIV_STAGES].quo <= QUO_CAP, "quotient above sticky cap")

endmodule

// ----- design/plane_intersection_direction_core.sv -----
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req_data (two planes, 12 x Q16.16)
// response  out        rsp_valid/rsp_stall  rsp_data (direction, parallel flag)
//
// One item per cycle while no stall holds either channel; the path has 7 front stages,
// one queue stage and 128 + FRAC_BITS + 4 back stages (156 in all at FRAC_BITS = 16).
// The fixed-point quotient is set by a pipelined restoring divider, one bit a stage.
// Reset is synchronous and clears only valid bits and the queue pointers and count.
// A stalled response freezes the back end; the front keeps filling the queue.
module plane_intersection_direction_core #(
   parameter int FRAC_BITS   = pid_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = pid_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pid_pkg::pid_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pid_pkg::pid_rsp_type rsp_data
);
   import pid_pkg::*;

   logic                 push, pop;
   pid_cls_type          push_data, pop_data;
   pid_queue_status_type queue_status;

   // Elimination and classification.
   pid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .push         (push),
      .push_data    (push_data),
      .queue_status (queue_status)
   );

   // Decoupling queue.
   pid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // Division and direction assembly.
   pid_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop          (pop),
      .pop_data     (pop_data),
      .queue_status (queue_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
